[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the scancode event queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(name, expr, msg) \
  `ASSERT_AT(name, !(expr), msg)

`endif

[design/kse_pkg.sv]
// ----------------------------------------------------------------------------
// kse_pkg
// Types, constants and the set-1 to US ASCII table of the scancode queue.
// ----------------------------------------------------------------------------
package kse_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int CNTR_W     = 32;
  localparam int WAIT_W     = 9;

  localparam logic [6:0] MOD_SHIFT_LEFT  = 7'h2A;
  localparam logic [6:0] MOD_SHIFT_RIGHT = 7'h36;
  localparam logic [6:0] MOD_CTRL_LEFT   = 7'h1D;
  localparam logic [6:0] MOD_ALT_LEFT    = 7'h38;
  localparam logic [6:0] TABLE_LEN       = 7'd59;

  typedef enum logic [1:0] {
    REQ_SCAN  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2
  } kse_req_e;

  typedef enum logic [2:0] {
    STS_POPPED   = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_DISABLED = 3'd2,
    STS_ACCEPTED = 3'd3,
    STS_DROPPED  = 3'd4,
    STS_CLEARED  = 3'd5
  } kse_status_e;

  typedef enum logic {
    S_IDLE,
    S_POP
  } kse_state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] scancode;
  } kse_in_t;

  typedef struct packed {
    logic [7:0] scancode;
    logic       pressed;
    logic       shift;
    logic       ctrl;
    logic       alt;
    logic [6:0] ascii;
  } kse_event_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        event_scancode;
    logic              event_pressed;
    logic              event_shift;
    logic              event_ctrl;
    logic              event_alt;
    logic [6:0]        event_ascii;
    logic [WAIT_W-1:0] events_waiting;
    logic [CNTR_W-1:0] presses_total;
    logic [CNTR_W-1:0] releases_total;
    logic [CNTR_W-1:0] overflows_total;
    logic [CNTR_W-1:0] invalid_total;
  } kse_out_t;

  // US layout, plain and shifted; keys without a character give zero.
  function automatic logic [6:0] kse_char(input logic [6:0] key, input logic shift);
    logic [6:0] ch;
    ch = 7'h00;
    case (key)
      7'd2:  ch = shift ? 7'h21 : 7'h31;
      7'd3:  ch = shift ? 7'h40 : 7'h32;
      7'd4:  ch = shift ? 7'h23 : 7'h33;
      7'd5:  ch = shift ? 7'h24 : 7'h34;
      7'd6:  ch = shift ? 7'h25 : 7'h35;
      7'd7:  ch = shift ? 7'h5E : 7'h36;
      7'd8:  ch = shift ? 7'h26 : 7'h37;
      7'd9:  ch = shift ? 7'h2A : 7'h38;
      7'd10: ch = shift ? 7'h28 : 7'h39;
      7'd11: ch = shift ? 7'h29 : 7'h30;
      7'd12: ch = shift ? 7'h5F : 7'h2D;
      7'd13: ch = shift ? 7'h2B : 7'h3D;
      7'd14: ch = 7'h08;
      7'd15: ch = 7'h09;
      7'd16: ch = shift ? 7'h51 : 7'h71;
      7'd17: ch = shift ? 7'h57 : 7'h77;
      7'd18: ch = shift ? 7'h45 : 7'h65;
      7'd19: ch = shift ? 7'h52 : 7'h72;
      7'd20: ch = shift ? 7'h54 : 7'h74;
      7'd21: ch = shift ? 7'h59 : 7'h79;
      7'd22: ch = shift ? 7'h55 : 7'h75;
      7'd23: ch = shift ? 7'h49 : 7'h69;
      7'd24: ch = shift ? 7'h4F : 7'h6F;
      7'd25: ch = shift ? 7'h50 : 7'h70;
      7'd26: ch = shift ? 7'h7B : 7'h5B;
      7'd27: ch = shift ? 7'h7D : 7'h5D;
      7'd28: ch = 7'h0A;
      7'd30: ch = shift ? 7'h41 : 7'h61;
      7'd31: ch = shift ? 7'h53 : 7'h73;
      7'd32: ch = shift ? 7'h44 : 7'h64;
      7'd33: ch = shift ? 7'h46 : 7'h66;
      7'd34: ch = shift ? 7'h47 : 7'h67;
      7'd35: ch = shift ? 7'h48 : 7'h68;
      7'd36: ch = shift ? 7'h4A : 7'h6A;
      7'd37: ch = shift ? 7'h4B : 7'h6B;
      7'd38: ch = shift ? 7'h4C : 7'h6C;
      7'd39: ch = shift ? 7'h3A : 7'h3B;
      7'd40: ch = shift ? 7'h22 : 7'h27;
      7'd41: ch = shift ? 7'h7E : 7'h60;
      7'd43: ch = shift ? 7'h7C : 7'h5C;
      7'd44: ch = shift ? 7'h5A : 7'h7A;
      7'd45: ch = shift ? 7'h58 : 7'h78;
      7'd46: ch = shift ? 7'h43 : 7'h63;
      7'd47: ch = shift ? 7'h56 : 7'h76;
      7'd48: ch = shift ? 7'h42 : 7'h62;
      7'd49: ch = shift ? 7'h4E : 7'h6E;
      7'd50: ch = shift ? 7'h4D : 7'h6D;
      7'd51: ch = shift ? 7'h3C : 7'h2C;
      7'd52: ch = shift ? 7'h3E : 7'h2E;
      7'd53: ch = shift ? 7'h3F : 7'h2F;
      7'd55: ch = 7'h2A;
      7'd57: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

[design/kse_ring_ram.sv]
// ----------------------------------------------------------------------------
// kse_ring_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kse_ring_ram #(
  parameter int Width = 19,
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/kse_xlate.sv]
// ----------------------------------------------------------------------------
// kse_xlate
// Modifier tracking and scancode to ASCII translation.
// ----------------------------------------------------------------------------
module kse_xlate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               scan_en_i,
  input  logic [7:0]         scancode_i,
  output kse_pkg::kse_event_t event_o,
  output logic               invalid_o
);
  import kse_pkg::*;

  logic       shift_q, shift_d;
  logic       ctrl_q, ctrl_d;
  logic       alt_q, alt_d;
  logic       released;
  logic [6:0] key;

  assign released = scancode_i[7];
  assign key      = scancode_i[6:0];

  always_comb begin
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    alt_d   = alt_q;
    if (key == MOD_SHIFT_LEFT || key == MOD_SHIFT_RIGHT) begin
      shift_d = !released;
    end else if (key == MOD_CTRL_LEFT) begin
      ctrl_d = !released;
    end else if (key == MOD_ALT_LEFT) begin
      alt_d = !released;
    end
  end

  // Event carries the modifiers as updated by this very scancode.
  always_comb begin
    event_o.scancode = scancode_i;
    event_o.pressed  = !released;
    event_o.shift    = shift_d;
    event_o.ctrl     = ctrl_d;
    event_o.alt      = alt_d;
    event_o.ascii    = kse_char(key, shift_d);
  end

  assign invalid_o = (key >= TABLE_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ctrl_q  <= 1'b0;
      alt_q   <= 1'b0;
    end else if (scan_en_i) begin
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      alt_q   <= alt_d;
    end
  end

endmodule

[design/keyboard_scancode_event_fifo.sv]
// ----------------------------------------------------------------------------
// keyboard_scancode_event_fifo
// Set-1 scancode translator with an event ring in block RAM and counters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------
//  in       | input     | in_valid_i / in_stall_o   | kse_in_t
//  out      | output    | out_valid_o / out_stall_i | kse_out_t
//  cfg      | input     | cfg_we_i                  | cfg_wdata_i
//
//  Scancode, clear and empty or disabled pop: result in the output register
//  at the transfer edge. A pop with data issues the ring RAM read, enters
//  S_POP, and there loads the registered read data into the output register.
//  Ring contents are not reset; pointers, count, modifiers and counters are.
//  Input stalls while a pop waits on RAM data or a result is held by out_stall_i.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_scancode_event_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kse_pkg::kse_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output kse_pkg::kse_out_t out_data_o
);
  import kse_pkg::*;

  kse_state_e        state_q, state_d;
  logic              enable_q;
  logic [RING_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RING_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  held_count_q, held_count_d;
  logic [CNTR_W-1:0] press_q, press_d;
  logic [CNTR_W-1:0] release_q, release_d;
  logic [CNTR_W-1:0] overflow_q, overflow_d;
  logic [CNTR_W-1:0] invalid_q, invalid_d;
  logic              out_valid_q, out_valid_d;
  kse_status_e       status_q, status_d;
  kse_event_t        evt_q, evt_d;

  logic       accept;
  logic       scan_en;
  logic       ring_full;
  logic       ram_we;
  logic       ram_re;
  kse_event_t new_evt;
  logic       new_invalid;
  logic [$bits(kse_event_t)-1:0] ram_rdata;

  function automatic logic [RING_AW-1:0] ptr_next(input logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_en    = accept && (in_data_i.req_type == REQ_SCAN);
  assign ring_full  = (held_count_q == CNT_W'(RING_DEPTH));

  kse_xlate u_xlate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_en_i  (scan_en),
    .scancode_i (in_data_i.scancode),
    .event_o    (new_evt),
    .invalid_o  (new_invalid)
  );

  kse_ring_ram #(
    .Width ($bits(kse_event_t)),
    .Depth (RING_DEPTH),
    .AddrW (RING_AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (new_evt),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Write and read never fall in the same cycle, so no forwarding is needed.
  always_comb begin
    state_d      = state_q;
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    held_count_d = held_count_q;
    press_d      = press_q;
    release_d    = release_q;
    overflow_d   = overflow_q;
    invalid_d    = invalid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    evt_d        = evt_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.req_type)
            REQ_SCAN: begin
              if (in_data_i.scancode[7]) begin
                release_d = release_q + 1'b1;
              end else begin
                press_d = press_q + 1'b1;
              end
              if (new_invalid) begin
                invalid_d = invalid_q + 1'b1;
              end
              if (ring_full) begin
                overflow_d = overflow_q + 1'b1;
                status_d   = STS_DROPPED;
              end else begin
                ram_we       = 1'b1;
                wr_ptr_d     = ptr_next(wr_ptr_q);
                held_count_d = held_count_q + 1'b1;
                status_d     = STS_ACCEPTED;
              end
              evt_d       = '0;
              out_valid_d = 1'b1;
            end
            REQ_POP: begin
              evt_d = '0;
              if (!enable_q) begin
                status_d    = STS_DISABLED;
                out_valid_d = 1'b1;
              end else if (held_count_q == '0) begin
                status_d    = STS_EMPTY;
                out_valid_d = 1'b1;
              end else begin
                // Issue the read; the result is presented once data returns.
                ram_re       = 1'b1;
                rd_ptr_d     = ptr_next(rd_ptr_q);
                held_count_d = held_count_q - 1'b1;
                status_d     = STS_POPPED;
                state_d      = S_POP;
              end
            end
            REQ_CLEAR: begin
              wr_ptr_d     = '0;
              rd_ptr_d     = '0;
              held_count_d = '0;
              status_d     = STS_CLEARED;
              evt_d        = '0;
              out_valid_d  = 1'b1;
            end
            default: begin
              // Unused request: drop with no result.
            end
          endcase
        end
      end
      S_POP: begin
        evt_d       = kse_event_t'(ram_rdata);
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      held_count_q <= '0;
      press_q      <= '0;
      release_q    <= '0;
      overflow_q   <= '0;
      invalid_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      held_count_q <= held_count_d;
      press_q      <= press_d;
      release_q    <= release_d;
      overflow_q   <= overflow_d;
      invalid_q    <= invalid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    evt_q    <= evt_d;
  end

  // Count and counters only move on a transfer in, which a held result blocks.
  always_comb begin
    out_data_o.status          = status_q;
    out_data_o.event_scancode  = evt_q.scancode;
    out_data_o.event_pressed   = evt_q.pressed;
    out_data_o.event_shift     = evt_q.shift;
    out_data_o.event_ctrl      = evt_q.ctrl;
    out_data_o.event_alt       = evt_q.alt;
    out_data_o.event_ascii     = evt_q.ascii;
    out_data_o.events_waiting  = WAIT_W'(held_count_q);
    out_data_o.presses_total   = press_q;
    out_data_o.releases_total  = release_q;
    out_data_o.overflows_total = overflow_q;
    out_data_o.invalid_total   = invalid_q;
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_NEVER(a_count_bound, held_count_q > CNT_W'(RING_DEPTH), "ring count beyond depth")
  `ASSERT_NEVER(a_ram_one_port, ram_we && ram_re, "ring write and read in one cycle")
  `ASSERT_NEVER(a_pop_slot_free, (state_q == S_POP) && out_valid_q, "pop data with result held")
  `ASSERT_AT(a_pop_result, (state_q == S_POP) |=> (out_valid_q && status_q == STS_POPPED), "pop result missing")

endmodule

[bench/kse_report_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_report_checker
// Watches the request, result and config ports of the scancode event queue,
// tracks modifiers, queued events and counters on its own, and compares every
// result transfer field by field against the oldest predicted report.
// ----------------------------------------------------------------------------
module kse_report_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  kse_pkg::kse_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  kse_pkg::kse_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import kse_pkg::*;

  // US layout by key code; zero where the key has no character.
  localparam logic [7:0] PLAIN_CHARS [0:TABLE_LEN-1] = '{
    8'h00, 8'h00, "1", "2", "3", "4", "5", "6",
    "7", "8", "9", "0", "-", "=", 8'h08, 8'h09,
    "q", "w", "e", "r", "t", "y", "u", "i",
    "o", "p", "[", "]", 8'h0A, 8'h00, "a", "s",
    "d", "f", "g", "h", "j", "k", "l", ";",
    "'", 8'h60, 8'h00, "\\", "z", "x", "c", "v",
    "b", "n", "m", ",", ".", "/", 8'h00, "*",
    8'h00, " ", 8'h00
  };

  localparam logic [7:0] SHIFTED_CHARS [0:TABLE_LEN-1] = '{
    8'h00, 8'h00, "!", "@", "#", "$", "%", "^",
    "&", "*", "(", ")", "_", "+", 8'h08, 8'h09,
    "Q", "W", "E", "R", "T", "Y", "U", "I",
    "O", "P", "{", "}", 8'h0A, 8'h00, "A", "S",
    "D", "F", "G", "H", "J", "K", "L", ":",
    "\"", "~", 8'h00, "|", "Z", "X", "C", "V",
    "B", "N", "M", "<", ">", "?", 8'h00, "*",
    8'h00, " ", 8'h00
  };

  logic        enabled;
  logic        shift_down;
  logic        ctrl_down;
  logic        alt_down;
  logic [31:0] presses;
  logic [31:0] releases;
  logic [31:0] overflows;
  logic [31:0] invalids;
  kse_event_t  queued_events [$];
  kse_out_t    awaited_reports [$];
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic note_failure(input string what);
    if (mismatches < 10) $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got)
      note_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // Advance the tracked queue state by one request and record the report.
  task automatic predict_report(input kse_in_t req);
    kse_out_t   rep;
    kse_event_t ev;
    logic [6:0] key;
    logic       released;
    rep = '0;
    case (req.req_type)
      REQ_SCAN: begin
        released = req.scancode[7];
        key      = req.scancode[6:0];
        if (key == MOD_SHIFT_LEFT || key == MOD_SHIFT_RIGHT) shift_down = !released;
        else if (key == MOD_CTRL_LEFT) ctrl_down = !released;
        else if (key == MOD_ALT_LEFT) alt_down = !released;
        ev.scancode = req.scancode;
        ev.pressed  = !released;
        ev.shift    = shift_down;
        ev.ctrl     = ctrl_down;
        ev.alt      = alt_down;
        if (key >= TABLE_LEN) begin
          ev.ascii = '0;
          invalids++;
        end else begin
          ev.ascii = shift_down ? SHIFTED_CHARS[key][6:0] : PLAIN_CHARS[key][6:0];
        end
        if (released) releases++;
        else presses++;
        if (queued_events.size() >= RING_DEPTH) begin
          overflows++;
          rep.status = STS_DROPPED;
        end else begin
          queued_events.push_back(ev);
          rep.status = STS_ACCEPTED;
        end
      end
      REQ_POP: begin
        if (!enabled) begin
          rep.status = STS_DISABLED;
        end else if (queued_events.size() == 0) begin
          rep.status = STS_EMPTY;
        end else begin
          ev = queued_events.pop_front();
          rep.status         = STS_POPPED;
          rep.event_scancode = ev.scancode;
          rep.event_pressed  = ev.pressed;
          rep.event_shift    = ev.shift;
          rep.event_ctrl     = ev.ctrl;
          rep.event_alt      = ev.alt;
          rep.event_ascii    = ev.ascii;
        end
      end
      REQ_CLEAR: begin
        queued_events.delete();
        rep.status = STS_CLEARED;
      end
      default: return;  // unused request: no report
    endcase
    rep.events_waiting  = WAIT_W'(queued_events.size());
    rep.presses_total   = presses;
    rep.releases_total  = releases;
    rep.overflows_total = overflows;
    rep.invalid_total   = invalids;
    awaited_reports.push_back(rep);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kse_out_t want;
    if (!rst_ni) begin
      enabled    = 1'b0;
      shift_down = 1'b0;
      ctrl_down  = 1'b0;
      alt_down   = 1'b0;
      presses    = '0;
      releases   = '0;
      overflows  = '0;
      invalids   = '0;
      queued_events.delete();
      awaited_reports.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_reports.size() == 0) begin
          note_failure($sformatf("result with nothing pending: 0x%0h", out_data_i));
        end else begin
          want = awaited_reports.pop_front();
          check_field("status", want.status, out_data_i.status);
          check_field("event_scancode", want.event_scancode, out_data_i.event_scancode);
          check_field("event_pressed", want.event_pressed, out_data_i.event_pressed);
          check_field("event_shift", want.event_shift, out_data_i.event_shift);
          check_field("event_ctrl", want.event_ctrl, out_data_i.event_ctrl);
          check_field("event_alt", want.event_alt, out_data_i.event_alt);
          check_field("event_ascii", want.event_ascii, out_data_i.event_ascii);
          check_field("events_waiting", want.events_waiting, out_data_i.events_waiting);
          check_field("presses_total", want.presses_total, out_data_i.presses_total);
          check_field("releases_total", want.releases_total, out_data_i.releases_total);
          check_field("overflows_total", want.overflows_total, out_data_i.overflows_total);
          check_field("invalid_total", want.invalid_total, out_data_i.invalid_total);
        end
      end
      if (cfg_we_i) enabled = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_report(in_data_i);
      pending_o <= awaited_reports.size();
    end
  end

endmodule

[bench/keyboard_scancode_event_fifo_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_event_fifo_test
// Drives scancodes, pops and clears into the event queue with random gaps and
// result stalls, toggles the enable register between phases, floods the ring
// past full, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module keyboard_scancode_event_fifo_test;
  import kse_pkg::*;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 4;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  kse_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kse_out_t out_data;
  int       fail_count;
  int       pending;
  bit       steady    = 1'b0;  // no idling on either side while set
  int       sent      = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  keyboard_scancode_event_fifo dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  kse_report_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Present one request and hold it until the transfer.
  task automatic push_request(input logic [1:0] kind, input logic [7:0] code);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, scancode: code};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind != REQ_UNUSED) sent++;
  endtask

  // Stop sending until every predicted result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Optional modifier, key press, usually its release, usually modifier release.
  task automatic type_stroke();
    logic [6:0] modifier;
    logic [6:0] key;
    bit         with_mod;
    with_mod = $urandom_range(0, 1);
    case ($urandom_range(0, 3))
      0:       modifier = MOD_SHIFT_LEFT;
      1:       modifier = MOD_SHIFT_RIGHT;
      2:       modifier = MOD_CTRL_LEFT;
      default: modifier = MOD_ALT_LEFT;
    endcase
    key = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(59, 127))
                                       : 7'($urandom_range(1, 58));
    if (with_mod) push_request(REQ_SCAN, {1'b0, modifier});
    push_request(REQ_SCAN, {1'b0, key});
    if ($urandom_range(0, 3) != 0) push_request(REQ_SCAN, {1'b1, key});
    if (with_mod && $urandom_range(0, 4) != 0) push_request(REQ_SCAN, {1'b1, modifier});
  endtask

  task automatic run_mixed(input int count);
    int target;
    int pick;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(0, 49) == 0) steady = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        type_stroke();
        repeat ($urandom_range(0, 3)) push_request(REQ_POP, 8'($urandom));
      end else if (pick < 75) begin
        push_request(REQ_POP, 8'($urandom));
      end else if (pick < 93) begin
        push_request(REQ_SCAN, 8'($urandom));
      end else if (pick < 97) begin
        push_request(REQ_CLEAR, 8'($urandom));
      end else begin
        push_request(REQ_UNUSED, 8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Stall each result a random number of cycles.
  initial begin : result_side
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled: scancodes still queue, pops are refused.
    push_request(REQ_POP, 8'h00);
    push_request(REQ_SCAN, 8'h1E);
    push_request(REQ_SCAN, 8'h9E);
    push_request(REQ_SCAN, 8'h2A);
    push_request(REQ_SCAN, 8'h10);
    push_request(REQ_SCAN, 8'h00);
    push_request(REQ_SCAN, 8'h3A);
    push_request(REQ_SCAN, 8'h3B);
    push_request(REQ_SCAN, 8'h7F);
    push_request(REQ_SCAN, 8'hFF);
    push_request(REQ_SCAN, 8'hAA);
    push_request(REQ_SCAN, 8'h36);
    push_request(REQ_SCAN, 8'hB6);
    push_request(REQ_SCAN, 8'h1D);
    push_request(REQ_SCAN, 8'h38);
    push_request(REQ_SCAN, 8'h39);
    push_request(REQ_SCAN, 8'h9D);
    push_request(REQ_SCAN, 8'hB8);
    push_request(REQ_UNUSED, 8'hFF);
    push_request(REQ_POP, 8'hFF);
    wait_idle();
    write_enable(1'b1);
    push_request(REQ_POP, 8'h00);
    push_request(REQ_POP, 8'h55);
    push_request(REQ_POP, 8'hAA);
    push_request(REQ_CLEAR, 8'h00);
    push_request(REQ_POP, 8'h00);

    run_mixed(500);
    wait_idle();
    write_enable(1'b0);
    run_mixed(150);
    wait_idle();
    write_enable(1'b1);

    // Flood the ring past full, then drain it to empty.
    steady = 1'b1;
    repeat (150) push_request(REQ_SCAN, 8'($urandom));
    steady = 1'b0;
    repeat (150) push_request(REQ_SCAN, 8'($urandom));
    repeat (270) push_request(REQ_POP, 8'($urandom));
    wait_idle();
    write_enable(1'b0);
    write_enable(1'b1);
    run_mixed(200);
    wait_idle();

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
